// File: src/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg: shared types and constants for the TGA RLE pixel decoder
// Beat payloads, configuration layout and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 32;

  localparam logic [CfgIndexWidth-1:0] REG_WIDE_PIXELS  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_RLE_MODE     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_TOTAL_PIXELS = 2'd2;

  localparam logic [7:0] COUNT_MASK = 8'h7F;
  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [31:0] color_argb;
    logic [31:0] first_pixel;
    logic [7:0]  pixel_count;
    logic        image_done;
  } out_item_t;

  typedef struct packed {
    logic        wide_pixels;
    logic        rle_mode;
    logic [31:0] total_pixels;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/tgarle_in_stage.sv
// ----------------------------------------------------------------------------
// tgarle_in_stage: input register
// Holds one accepted byte beat until the decode stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_in_stage
  import tgarle_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     consume,
  output logic          held_valid,
  output in_item_t      held_data
);

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: src/tgarle_core.sv
// ----------------------------------------------------------------------------
// tgarle_core: decode state and per-byte logic
// Packet header parsing, pixel assembly and run clipping for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_core
  import tgarle_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire in_item_t item,
  input  wire logic     fire,
  output logic          res_valid,
  output out_item_t     res
);

  logic [31:0] pixels_written, pixels_written_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] partial_pixel, partial_pixel_next;
  logic        image_complete, image_complete_next;

  // state as seen by this byte, after an optional start-of-image clear
  logic [31:0] cur_written;
  logic [7:0]  cur_left;
  logic        cur_run;
  logic [1:0]  cur_bip;
  logic [23:0] cur_partial;
  logic        cur_complete;

  logic        ignore, header, gather;
  logic [1:0]  last_pos;
  logic [31:0] remaining, written_sum;
  logic [7:0]  count_raw, count;
  logic [31:0] color;
  logic        done;

  always_comb begin
    cur_written  = item.start_of_image ? '0 : pixels_written;
    cur_left     = item.start_of_image ? '0 : packet_left;
    cur_run      = item.start_of_image ? 1'b0 : packet_is_run;
    cur_bip      = item.start_of_image ? '0 : byte_in_pixel;
    cur_partial  = item.start_of_image ? '0 : partial_pixel;
    cur_complete = item.start_of_image ? 1'b0 : image_complete;

    ignore   = cur_complete || (cur_written >= cfg.total_pixels);
    header   = cfg.rle_mode && (cur_left == 8'd0);
    last_pos = cfg.wide_pixels ? 2'd3 : 2'd2;
    gather   = cur_bip < last_pos;

    color = cfg.wide_pixels ? {item.data_byte, cur_partial}
                            : {ALPHA_OPAQUE, item.data_byte, cur_partial[15:0]};

    remaining = cfg.total_pixels - cur_written;
    count_raw = (cfg.rle_mode && cur_run) ? cur_left : 8'd1;
    count     = (remaining < {24'd0, count_raw}) ? remaining[7:0] : count_raw;
    written_sum = cur_written + {24'd0, count};
    done        = written_sum == cfg.total_pixels;

    pixels_written_next = cur_written;
    packet_left_next    = cur_left;
    packet_is_run_next  = cur_run;
    byte_in_pixel_next  = cur_bip;
    partial_pixel_next  = cur_partial;
    image_complete_next = cur_complete;
    res_valid           = 1'b0;

    priority if (ignore) begin
      // nothing past the clear
    end else if (header) begin
      packet_left_next   = (item.data_byte & COUNT_MASK) + 8'd1;
      packet_is_run_next = (item.data_byte & RUN_FLAG) != 8'd0;
    end else if (gather) begin
      unique case (cur_bip)
        2'd0:    partial_pixel_next = cur_partial | {16'd0, item.data_byte};
        2'd1:    partial_pixel_next = cur_partial | {8'd0, item.data_byte, 8'd0};
        default: partial_pixel_next = cur_partial | {item.data_byte, 16'd0};
      endcase
      byte_in_pixel_next = cur_bip + 2'd1;
    end else begin
      res_valid           = 1'b1;
      byte_in_pixel_next  = '0;
      partial_pixel_next  = '0;
      pixels_written_next = written_sum;
      if (cfg.rle_mode && cur_run) begin
        packet_left_next = 8'd0;
      end else if (cfg.rle_mode) begin
        packet_left_next = cur_left - 8'd1;
      end
      if (done) begin
        image_complete_next = 1'b1;
        packet_left_next    = 8'd0;
      end
    end

    res.color_argb  = color;
    res.first_pixel = cur_written;
    res.pixel_count = count;
    res.image_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_written <= '0;
      packet_left    <= '0;
      packet_is_run  <= 1'b0;
      byte_in_pixel  <= '0;
      partial_pixel  <= '0;
      image_complete <= 1'b0;
    end else if (fire) begin
      pixels_written <= pixels_written_next;
      packet_left    <= packet_left_next;
      packet_is_run  <= packet_is_run_next;
      byte_in_pixel  <= byte_in_pixel_next;
      partial_pixel  <= partial_pixel_next;
      image_complete <= image_complete_next;
    end
  end

  // a finished image always waits for a new header
  a_done_no_packet: assert property (@(posedge clk) disable iff (rst)
    image_complete |-> packet_left == 8'd0)
    else $error("packet still open after image completion");

  // a run that finishes the image marks it complete
  a_done_sets_complete: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.image_done) |=> image_complete)
    else $error("image not marked complete after final run");

  // runs never overshoot the image
  a_count_clipped: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.pixel_count != 8'd0) && ({24'd0, res.pixel_count} <= remaining))
    else $error("run length outside remaining pixels");

endmodule

`default_nettype wire

// File: src/tgarle_out_reg.sv
// ----------------------------------------------------------------------------
// tgarle_out_reg: result register
// Holds one run beat for the receiver and reports whether it can take another.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_out_reg
  import tgarle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t load_data,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// File: src/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: TGA pixel-data stream to color runs
// Decodes 24/32-bit uncompressed or run-length TGA pixel bytes into runs.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one pixel-data byte per beat,
//    with start_of_image marking the first byte of a new image.
//  - Output channel (out_valid/out_ready/out_data): one run per beat: ARGB
//    color, first pixel index in file order, length 1..128, and a flag on the
//    run that completes the image. Header bytes, partial pixels and bytes
//    past the end of the image produce no beat.
//  - Config port (cfg_we/cfg_index/cfg_data): wide_pixels, rle_mode, total_pixels;
//    the user must write them only while the block is idle; it does not enforce this.
//  - Throughput: one byte per clock unless the receiver stalls. The per-byte
//    decode is a single register-to-register pass (input register, decode
//    logic, result register).
//  - Run path: last byte of a run -> input register -> decode logic -> result register.
//  - Reset (rst, synchronous): counters cleared, no beat pending, registers
//    back to 24-bit raw mode with total_pixels of one.
//  - Receiver stall: the result register holds its run; the input register
//    still takes one more byte, and bytes that make no run keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      held_valid;
  in_item_t  held_data;
  logic      consume;
  logic      res_valid;
  out_item_t res;
  logic      can_load;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wide_pixels  <= 1'b0;
      cfg.rle_mode     <= 1'b0;
      cfg.total_pixels <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDE_PIXELS:  cfg.wide_pixels  <= cfg_data[0];
        REG_RLE_MODE:     cfg.rle_mode     <= cfg_data[0];
        REG_TOTAL_PIXELS: cfg.total_pixels <= cfg_data;
        default: ;
      endcase
    end
  end

  // a held byte moves on unless it makes a run and the result slot is full
  assign consume = held_valid && (!res_valid || can_load);

  tgarle_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .consume    (consume),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  tgarle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (held_data),
    .fire      (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  tgarle_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && res_valid),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
